// ----- sv/hrve_pkg.sv -----
// Shared types, constants and helper functions for the hex ring vertex expander.
package hrve_pkg;

    localparam int MAG_W   = 16;
    localparam int SQ_W    = 32;
    localparam int LEN_W   = 24;
    localparam int VW      = 2 * LEN_W;
    localparam int REM_W   = 26;
    localparam int QUO_W   = 16;
    localparam int NUM_W   = 39;
    localparam int SQRT_ST = 12;
    localparam int DIV_ST  = 8;

    localparam logic [15:0] ONE_Q14 = 16'd16384;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHELL_RADIUS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLE_THRESHOLD = 2'd2;

    localparam logic [15:0] CELL_RADIUS_RST    = 16'd2458;
    localparam logic [14:0] SHELL_RADIUS_RST   = 15'd16417;
    localparam logic [14:0] POLE_THRESHOLD_RST = 15'd15073;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam logic [63:0] SIN_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};
    localparam logic [63:0] COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                            64'd90, 64'd132, 64'd182};

    typedef logic signed [15:0] q14_t;

    typedef struct packed {
        q14_t x;
        q14_t y;
        q14_t z;
    } vec_t;

    typedef struct packed {
        logic [15:0] scale;
        logic [15:0] energy;
    } cell_info_t;

    typedef struct packed {
        vec_t       u;
        cell_info_t info;
    } t_side_t;

    typedef struct packed {
        vec_t       u;
        vec_t       t;
        cell_info_t info;
    } b_side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [LEN_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [LEN_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_t;

    // one radix-4 digit of the restoring square root
    function automatic sq_t sqrt_step(sq_t s, logic [1:0] d);
        logic [REM_W+1:0] r2;
        logic [REM_W+1:0] tr;
        logic             ge;
        sq_t              o;
        r2 = {s.rem, d};
        tr = {2'b00, s.root, 2'b01};
        ge = (r2 >= tr);
        o.rem  = ge ? REM_W'(r2 - tr) : r2[REM_W-1:0];
        o.root = {s.root[LEN_W-2:0], ge};
        return o;
    endfunction

    // one quotient bit of the restoring division
    function automatic div_t div_step(div_t s, logic b, logic [LEN_W-1:0] l);
        logic [LEN_W:0] r2;
        logic           ge;
        div_t           o;
        r2 = {s.rem, b};
        ge = (r2 >= {1'b0, l});
        o.rem = ge ? LEN_W'(r2 - {1'b0, l}) : r2[LEN_W-1:0];
        o.quo = {s.quo[QUO_W-2:0], ge};
        return o;
    endfunction

    // round half away from zero by 2^14
    function automatic logic signed [16:0] rnd14(logic signed [32:0] v);
        logic        neg;
        logic [32:0] mag;
        logic [32:0] sum;
        logic [16:0] r;
        neg = v[32];
        mag = neg ? 33'(-v) : 33'(v);
        sum = mag + 33'd8192;
        r   = sum[30:14];
        return neg ? 17'(-r) : r;
    endfunction

    // round half away from zero by 2^44, saturate to 16 bits
    function automatic q14_t sat44(logic signed [63:0] p);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] sum;
        logic [19:0] rm;
        q14_t        o;
        neg = p[63];
        mag = neg ? 64'(-p) : 64'(p);
        sum = mag + (64'd1 << 43);
        rm  = sum[63:44];
        if (neg)
        begin
            o = (rm > 20'd32768) ? 16'sh8000 : 16'(~rm[15:0] + 16'd1);
        end
        else
        begin
            o = (rm > 20'd32767) ? 16'sh7fff : rm[15:0];
        end
        return o;
    endfunction

    // cos and sin in Q14 of a Q30 angle in [0, pi/2); {cos, sin}
    function automatic logic [31:0] trig_q14(logic [63:0] a);
        logic [63:0]        x2;
        logic [63:0]        ts;
        logic [63:0]        tc;
        logic signed [63:0] ss;
        logic signed [63:0] cs;
        logic [63:0]        sr;
        logic [63:0]        cr;
        x2 = (a * a) >> 30;
        ts = a;
        tc = 64'd1 << 30;
        ss = $signed(a);
        cs = $signed(64'd1 << 30);
        for (int n = 1; n <= 7; n++)
        begin
            ts = ((ts * x2) >> 30) / SIN_DIV[n-1];
            tc = ((tc * x2) >> 30) / COS_DIV[n-1];
            if (n % 2 == 1)
            begin
                ss = ss - $signed(ts);
                cs = cs - $signed(tc);
            end
            else
            begin
                ss = ss + $signed(ts);
                cs = cs + $signed(tc);
            end
        end
        if (ss < 0) ss = 0;
        if (cs < 0) cs = 0;
        sr = (64'(ss) + 64'd32768) >> 16;
        cr = (64'(cs) + 64'd32768) >> 16;
        if (sr > 64'd16384) sr = 64'd16384;
        if (cr > 64'd16384) cr = 64'd16384;
        return {cr[15:0], sr[15:0]};
    endfunction

endpackage

// ----- sv/hrve_norm.sv -----
// Pipelined vector normalizer: squares, square root and three divisions to Q2.14.
module hrve_norm
    import hrve_pkg::*;
#(
    parameter int PW = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic signed [16:0]  in_x,
    input  logic signed [16:0]  in_y,
    input  logic signed [16:0]  in_z,
    input  logic [PW-1:0]       in_side,
    output logic                out_valid,
    output q14_t                out_x,
    output q14_t                out_y,
    output q14_t                out_z,
    output logic [PW-1:0]       out_side
);

    typedef struct packed {
        logic [PW-1:0]               side;
        logic                        zero;
        logic [2:0]                  neg;
        logic [2:0][MAG_W-1:0]       mag;
    } carry_t;

    logic signed [16:0] in_c [3];
    carry_t             c0_next;
    logic [SQ_W-1:0]    sq0_next [3];

    logic               v0_reg;
    carry_t             c0_reg;
    logic [SQ_W-1:0]    sq0_reg [3];

    logic [SQ_W-1:0]    sum_s;
    carry_t             sc0_next;

    logic               sv_reg [SQRT_ST+1];
    carry_t             sc_reg [SQRT_ST+1];
    logic [VW-1:0]      sw_reg [SQRT_ST+1];
    sq_t                ss_reg [SQRT_ST+1];
    sq_t                ss_next [SQRT_ST];

    div_t               di_next [3];
    logic [QUO_W-1:0]   dlow_init [3];

    logic               dv_reg [DIV_ST+1];
    carry_t             dc_reg [DIV_ST+1];
    logic [LEN_W-1:0]   dl_reg [DIV_ST+1];
    logic [QUO_W-1:0]   dlow_reg [DIV_ST+1][3];
    div_t               dd_reg [DIV_ST+1][3];
    div_t               dd_next [DIV_ST][3];

    q14_t               o_next [3];
    logic               ov_reg;
    q14_t               o_reg [3];
    logic [PW-1:0]      os_reg;

    assign in_c[0] = in_x;
    assign in_c[1] = in_y;
    assign in_c[2] = in_z;

    always_comb
    begin
        logic signed [16:0] a;
        c0_next.side = in_side;
        c0_next.zero = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            c0_next.neg[i] = in_c[i][16];
            a = in_c[i][16] ? -in_c[i] : in_c[i];
            c0_next.mag[i] = a[MAG_W-1:0];
            sq0_next[i] = SQ_W'(c0_next.mag[i]) * SQ_W'(c0_next.mag[i]);
        end
    end

    always_comb
    begin
        sum_s = sq0_reg[0] + sq0_reg[1] + sq0_reg[2];
        sc0_next = c0_reg;
        sc0_next.zero = (sum_s == '0);
    end

    always_comb
    begin
        sq_t t1;
        for (int k = 0; k < SQRT_ST; k++)
        begin
            t1 = sqrt_step(ss_reg[k], sw_reg[k][VW-1 -: 2]);
            ss_next[k] = sqrt_step(t1, sw_reg[k][VW-3 -: 2]);
        end
    end

    always_comb
    begin
        logic [LEN_W-1:0] l;
        logic [NUM_W-1:0] num;
        l = ss_reg[SQRT_ST].root;
        for (int i = 0; i < 3; i++)
        begin
            num = {1'b0, sc_reg[SQRT_ST].mag[i], 22'd0} + NUM_W'(l >> 1);
            di_next[i].rem = LEN_W'(num[NUM_W-1:QUO_W]);
            di_next[i].quo = '0;
            dlow_init[i]   = num[QUO_W-1:0];
        end
    end

    always_comb
    begin
        div_t t1;
        for (int k = 0; k < DIV_ST; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t1 = div_step(dd_reg[k][i], dlow_reg[k][i][QUO_W-1], dl_reg[k]);
                dd_next[k][i] = div_step(t1, dlow_reg[k][i][QUO_W-2], dl_reg[k]);
            end
        end
    end

    always_comb
    begin
        logic [QUO_W-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            q = dd_reg[DIV_ST][i].quo;
            if (q > ONE_Q14) q = ONE_Q14;
            o_next[i] = dc_reg[DIV_ST].neg[i] ? -$signed(q) : $signed(q);
            if (dc_reg[DIV_ST].zero)
            begin
                o_next[i] = (i == 1) ? $signed(ONE_Q14) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int k = 0; k <= SQRT_ST; k++) sv_reg[k] <= 1'b0;
            for (int k = 0; k <= DIV_ST; k++) dv_reg[k] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg    <= in_valid;
            sv_reg[0] <= v0_reg;
            for (int k = 0; k < SQRT_ST; k++) sv_reg[k+1] <= sv_reg[k];
            dv_reg[0] <= sv_reg[SQRT_ST];
            for (int k = 0; k < DIV_ST; k++) dv_reg[k+1] <= dv_reg[k];
            ov_reg    <= dv_reg[DIV_ST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg <= c0_next;
            for (int i = 0; i < 3; i++) sq0_reg[i] <= sq0_next[i];

            sc_reg[0] <= sc0_next;
            sw_reg[0] <= {sum_s, 16'd0};
            ss_reg[0] <= '0;
            for (int k = 0; k < SQRT_ST; k++)
            begin
                sc_reg[k+1] <= sc_reg[k];
                sw_reg[k+1] <= {sw_reg[k][VW-5:0], 4'd0};
                ss_reg[k+1] <= ss_next[k];
            end

            dc_reg[0] <= sc_reg[SQRT_ST];
            dl_reg[0] <= ss_reg[SQRT_ST].root;
            for (int i = 0; i < 3; i++)
            begin
                dd_reg[0][i]   <= di_next[i];
                dlow_reg[0][i] <= dlow_init[i];
            end
            for (int k = 0; k < DIV_ST; k++)
            begin
                dc_reg[k+1] <= dc_reg[k];
                dl_reg[k+1] <= dl_reg[k];
                for (int i = 0; i < 3; i++)
                begin
                    dd_reg[k+1][i]   <= dd_next[k][i];
                    dlow_reg[k+1][i] <= {dlow_reg[k][i][QUO_W-3:0], 2'b00};
                end
            end

            for (int i = 0; i < 3; i++) o_reg[i] <= o_next[i];
            os_reg <= dc_reg[DIV_ST].side;
        end
    end

    assign out_valid = ov_reg;
    assign out_x     = o_reg[0];
    assign out_y     = o_reg[1];
    assign out_z     = o_reg[2];
    assign out_side  = os_reg;

endmodule

// ----- sv/hex_ring_vertex_expander.sv -----
// Throughput: one vertex per cycle while vertex_stall is low. The vertex sequencer
// walks the ring corners of the cell it holds. The front end (three normalizers,
// cross product) takes a new cell every cycle while cell_stall is low.
// Reset: valid bits and vertex counter clear, config registers return to defaults.
// No clearing pass after reset.
module hex_ring_vertex_expander
    import hrve_pkg::*;
#(
    parameter int SIDES = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 cell_valid,
    output logic                 cell_stall,
    input  q14_t                 normal_x,
    input  q14_t                 normal_y,
    input  q14_t                 normal_z,
    input  logic [15:0]          cell_scale,
    input  logic [15:0]          cell_energy,
    output logic                 vertex_valid,
    input  logic                 vertex_stall,
    output q14_t                 pos_x,
    output q14_t                 pos_y,
    output q14_t                 pos_z,
    output q14_t                 unit_x,
    output q14_t                 unit_y,
    output q14_t                 unit_z,
    output logic [15:0]          vertex_energy,
    output logic [3:0]           vertex_index,
    output logic                 last_vertex
);

    localparam int SEGS  = (SIDES > 6) ? 6 : SIDES;
    localparam int TOTAL = 2 * SEGS;
    localparam logic [3:0] LAST_V = 4'(TOTAL - 1);
    localparam int CW = $clog2(SIDES);

    // corner table
    q14_t cos_tab [SIDES];
    q14_t sin_tab [SIDES];

    for (genvar j = 0; j < SIDES; j++)
    begin : g_trig
        localparam int M  = 2 * j + 1;
        localparam int Q  = (2 * M) / SIDES;
        localparam int R  = 2 * M - Q * SIDES;
        localparam int QM = Q % 4;
        localparam logic [63:0] ANG = (64'(R) * PI_Q30) / (2 * SIDES);
        localparam logic [31:0] CS = trig_q14(ANG);
        localparam q14_t C0 = CS[31:16];
        localparam q14_t S0 = CS[15:0];
        localparam q14_t CJ = (QM == 0) ? C0 : (QM == 1) ? -S0 : (QM == 2) ? -C0 : S0;
        localparam q14_t SJ = (QM == 0) ? S0 : (QM == 1) ? C0 : (QM == 2) ? -S0 : -C0;
        assign cos_tab[j] = CJ;
        assign sin_tab[j] = SJ;
    end

    // configuration
    logic [15:0] cell_radius_reg;
    logic [14:0] shell_radius_reg;
    logic [14:0] pole_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_radius_reg    <= CELL_RADIUS_RST;
            shell_radius_reg   <= SHELL_RADIUS_RST;
            pole_threshold_reg <= POLE_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CELL_RADIUS:    cell_radius_reg    <= cfg_data;
                REG_SHELL_RADIUS:   shell_radius_reg   <= cfg_data[14:0];
                REG_POLE_THRESHOLD: pole_threshold_reg <= cfg_data[14:0];
                default:            ;
            endcase
        end
    end

    logic adv;
    logic eadv;

    // unit normal
    cell_info_t in_info;
    logic       nu_valid;
    q14_t       nu_x;
    q14_t       nu_y;
    q14_t       nu_z;
    cell_info_t nu_info;

    assign in_info.scale  = cell_scale;
    assign in_info.energy = cell_energy;

    hrve_norm #(.PW($bits(cell_info_t))) u_norm_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cell_valid),
        .in_x      ({normal_x[15], normal_x}),
        .in_y      ({normal_y[15], normal_y}),
        .in_z      ({normal_z[15], normal_z}),
        .in_side   (in_info),
        .out_valid (nu_valid),
        .out_x     (nu_x),
        .out_y     (nu_y),
        .out_z     (nu_z),
        .out_side  (nu_info)
    );

    // tangent
    logic [15:0]        uy_abs;
    logic               pole;
    logic signed [16:0] tin_x;
    logic signed [16:0] tin_y;
    logic signed [16:0] tin_z;
    t_side_t            tin_side;

    always_comb
    begin
        uy_abs = nu_y[15] ? 16'(-nu_y) : nu_y;
        pole   = uy_abs > {1'b0, pole_threshold_reg};
        if (pole)
        begin
            tin_x = '0;
            tin_y = -$signed({nu_z[15], nu_z});
            tin_z = {nu_y[15], nu_y};
        end
        else
        begin
            tin_x = {nu_z[15], nu_z};
            tin_y = '0;
            tin_z = -$signed({nu_x[15], nu_x});
        end
        tin_side.u.x  = nu_x;
        tin_side.u.y  = nu_y;
        tin_side.u.z  = nu_z;
        tin_side.info = nu_info;
    end

    logic    nt_valid;
    q14_t    nt_x;
    q14_t    nt_y;
    q14_t    nt_z;
    t_side_t nt_side;

    hrve_norm #(.PW($bits(t_side_t))) u_norm_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (nu_valid),
        .in_x      (tin_x),
        .in_y      (tin_y),
        .in_z      (tin_z),
        .in_side   (tin_side),
        .out_valid (nt_valid),
        .out_x     (nt_x),
        .out_y     (nt_y),
        .out_z     (nt_z),
        .out_side  (nt_side)
    );

    // cross product u x t
    b_side_t            x_side_next;
    logic               x1v_reg;
    b_side_t            x1s_reg;
    logic signed [31:0] xp_reg [6];
    logic               x2v_reg;
    b_side_t            x2s_reg;
    logic signed [16:0] xb_reg [3];

    always_comb
    begin
        x_side_next.u    = nt_side.u;
        x_side_next.t.x  = nt_x;
        x_side_next.t.y  = nt_y;
        x_side_next.t.z  = nt_z;
        x_side_next.info = nt_side.info;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1v_reg <= 1'b0;
            x2v_reg <= 1'b0;
        end
        else if (adv)
        begin
            x1v_reg <= nt_valid;
            x2v_reg <= x1v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1s_reg   <= x_side_next;
            xp_reg[0] <= nt_side.u.y * nt_z;
            xp_reg[1] <= nt_side.u.z * nt_y;
            xp_reg[2] <= nt_side.u.z * nt_x;
            xp_reg[3] <= nt_side.u.x * nt_z;
            xp_reg[4] <= nt_side.u.x * nt_y;
            xp_reg[5] <= nt_side.u.y * nt_x;
            x2s_reg   <= x1s_reg;
            xb_reg[0] <= rnd14(33'(xp_reg[0]) - 33'(xp_reg[1]));
            xb_reg[1] <= rnd14(33'(xp_reg[2]) - 33'(xp_reg[3]));
            xb_reg[2] <= rnd14(33'(xp_reg[4]) - 33'(xp_reg[5]));
        end
    end

    // bitangent
    logic    nb_valid;
    q14_t    nb_x;
    q14_t    nb_y;
    q14_t    nb_z;
    b_side_t nb_side;

    hrve_norm #(.PW($bits(b_side_t))) u_norm_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (x2v_reg),
        .in_x      (xb_reg[0]),
        .in_y      (xb_reg[1]),
        .in_z      (xb_reg[2]),
        .in_side   (x2s_reg),
        .out_valid (nb_valid),
        .out_x     (nb_x),
        .out_y     (nb_y),
        .out_z     (nb_z),
        .out_side  (nb_side)
    );

    // vertex sequencer
    logic        cv_reg;
    logic        cv_next;
    logic [3:0]  vcnt_reg;
    logic [3:0]  vcnt_next;
    q14_t        cu_reg [3];
    q14_t        ct_reg [3];
    q14_t        cb_reg [3];
    logic [31:0] crad_reg;
    logic [15:0] ceng_reg;

    logic        issue_last;
    logic        load_ok;
    logic        load;
    logic [3:0]  corner_raw;
    logic [3:0]  corner_w;
    logic [CW-1:0] corner;
    q14_t        cos_v;
    q14_t        sin_v;

    logic        ov_reg;

    assign eadv       = !ov_reg || !vertex_stall;
    assign issue_last = (vcnt_reg == LAST_V);
    assign load_ok    = !cv_reg || (eadv && issue_last);
    assign load       = nb_valid && load_ok;
    assign adv        = !nb_valid || load_ok;
    assign cell_stall = !adv;

    always_comb
    begin
        cv_next   = cv_reg;
        vcnt_next = vcnt_reg;
        if (cv_reg && eadv)
        begin
            if (issue_last)
            begin
                vcnt_next = '0;
                cv_next   = 1'b0;
            end
            else
            begin
                vcnt_next = vcnt_reg + 4'd1;
            end
        end
        if (load)
        begin
            cv_next   = 1'b1;
            vcnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg   <= 1'b0;
            vcnt_reg <= '0;
        end
        else
        begin
            cv_reg   <= cv_next;
            vcnt_reg <= vcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cu_reg[0] <= nb_side.u.x;
            cu_reg[1] <= nb_side.u.y;
            cu_reg[2] <= nb_side.u.z;
            ct_reg[0] <= nb_side.t.x;
            ct_reg[1] <= nb_side.t.y;
            ct_reg[2] <= nb_side.t.z;
            cb_reg[0] <= nb_x;
            cb_reg[1] <= nb_y;
            cb_reg[2] <= nb_z;
            crad_reg  <= 32'(cell_radius_reg) * 32'(nb_side.info.scale);
            ceng_reg  <= nb_side.info.energy;
        end
    end

    always_comb
    begin
        corner_raw = {1'b0, vcnt_reg[3:1]} + {3'b000, vcnt_reg[0]};
        corner_w   = (corner_raw >= 4'(SIDES)) ? corner_raw - 4'(SIDES) : corner_raw;
        corner     = corner_w[CW-1:0];
        cos_v      = cos_tab[corner];
        sin_v      = sin_tab[corner];
    end

    // stage A: table products
    logic               av_reg;
    logic signed [31:0] tc_reg [3];
    logic signed [31:0] bs_reg [3];
    logic signed [31:0] usha_reg [3];
    q14_t               ua_reg [3];
    logic [31:0]        rada_reg;
    logic [15:0]        enga_reg;
    logic [3:0]         idxa_reg;
    logic               lasta_reg;

    // stage B: radius product
    logic               bv_reg;
    logic signed [63:0] prod_reg [3];
    logic signed [63:0] prod_next [3];
    logic signed [31:0] ushb_reg [3];
    q14_t               ub_reg [3];
    logic [15:0]        engb_reg;
    logic [3:0]         idxb_reg;
    logic               lastb_reg;

    // stage C: output
    q14_t               pos_next [3];
    q14_t               pos_reg [3];
    q14_t               uo_reg [3];
    logic [15:0]        engo_reg;
    logic [3:0]         idxo_reg;
    logic               lasto_reg;

    always_comb
    begin
        logic signed [32:0] s;
        logic signed [65:0] pf;
        for (int i = 0; i < 3; i++)
        begin
            s  = 33'(tc_reg[i]) + 33'(bs_reg[i]);
            pf = $signed({1'b0, rada_reg}) * s;
            prod_next[i] = pf[63:0];
        end
    end

    always_comb
    begin
        logic signed [63:0] p;
        for (int i = 0; i < 3; i++)
        begin
            p = $signed({{2{ushb_reg[i][31]}}, ushb_reg[i], 30'd0}) + prod_reg[i];
            pos_next[i] = sat44(p);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            av_reg <= 1'b0;
            bv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (eadv)
        begin
            av_reg <= cv_reg;
            bv_reg <= av_reg;
            ov_reg <= bv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eadv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tc_reg[i]   <= ct_reg[i] * cos_v;
                bs_reg[i]   <= cb_reg[i] * sin_v;
                usha_reg[i] <= cu_reg[i] * $signed({1'b0, shell_radius_reg});
                ua_reg[i]   <= cu_reg[i];
                prod_reg[i] <= prod_next[i];
                ushb_reg[i] <= usha_reg[i];
                ub_reg[i]   <= ua_reg[i];
                pos_reg[i]  <= pos_next[i];
                uo_reg[i]   <= ub_reg[i];
            end
            rada_reg  <= crad_reg;
            enga_reg  <= ceng_reg;
            idxa_reg  <= vcnt_reg;
            lasta_reg <= issue_last;
            engb_reg  <= enga_reg;
            idxb_reg  <= idxa_reg;
            lastb_reg <= lasta_reg;
            engo_reg  <= engb_reg;
            idxo_reg  <= idxb_reg;
            lasto_reg <= lastb_reg;
        end
    end

    assign vertex_valid  = ov_reg;
    assign pos_x         = pos_reg[0];
    assign pos_y         = pos_reg[1];
    assign pos_z         = pos_reg[2];
    assign unit_x        = uo_reg[0];
    assign unit_y        = uo_reg[1];
    assign unit_z        = uo_reg[2];
    assign vertex_energy = engo_reg;
    assign vertex_index  = idxo_reg;
    assign last_vertex   = lasto_reg;

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the hex ring vertex expander: predicted vertex rings checked against the block.
module tb_top
    import hrve_pkg::*;
;

    localparam int SIDES = 6;
    localparam int SEGS = (SIDES > 6) ? 6 : SIDES;
    localparam int RING_LEN = 2 * SEGS;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE = 120;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        q14_t        nx;
        q14_t        ny;
        q14_t        nz;
        logic [15:0] scale;
        logic [15:0] energy;
    } cell_t;

    typedef struct packed {
        q14_t        px;
        q14_t        py;
        q14_t        pz;
        q14_t        ux;
        q14_t        uy;
        q14_t        uz;
        logic [15:0] energy;
        logic [3:0]  index;
        logic        last;
    } vertex_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } tri_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic        cell_valid;
    logic        cell_stall;
    q14_t        normal_x;
    q14_t        normal_y;
    q14_t        normal_z;
    logic [15:0] cell_scale;
    logic [15:0] cell_energy;
    logic        vertex_valid;
    logic        vertex_stall;
    q14_t        pos_x;
    q14_t        pos_y;
    q14_t        pos_z;
    q14_t        unit_x;
    q14_t        unit_y;
    q14_t        unit_z;
    logic [15:0] vertex_energy;
    logic [3:0]  vertex_index;
    logic        last_vertex;

    cell_t   cell_q[$];
    vertex_t ring_q[$];
    longint  radius_reg;
    longint  shell_reg;
    longint  pole_reg;
    int      mismatches;
    int      failures;
    int      cycles;
    int      holds_asked;
    int      holds_done;
    int      hold_left;
    int      stall_win;
    int      stall_mode;
    int      burst_left;
    int      gap_left;

    hex_ring_vertex_expander #(.SIDES(SIDES)) dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_part(longint c, longint unsigned len);
        longint unsigned m;
        longint unsigned q;
        m = (c < 0) ? -c : c;
        q = ((m << 22) + (len >> 1)) / len;
        if (q > 16384) q = 16384;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic tri_t unitize(longint x, longint y, longint z);
        longint unsigned s;
        longint unsigned len;
        tri_t o;
        s = x * x + y * y + z * z;
        if (s == 0)
        begin
            o.x = 0;
            o.y = 16384;
            o.z = 0;
            return o;
        end
        len = root_floor(s << 16);
        o.x = unit_part(x, len);
        o.y = unit_part(y, len);
        o.z = unit_part(z, len);
        return o;
    endfunction

    function automatic longint round_away(longint v, int sh);
        longint unsigned half;
        longint unsigned m;
        half = 64'd1 << (sh - 1);
        if (v < 0)
        begin
            m = -v;
            return -longint'((m + half) >> sh);
        end
        m = v;
        return longint'((m + half) >> sh);
    endfunction

    // series cos/sin of the first-quadrant residue, then quadrant fold
    task automatic corner_trig(input int j, output longint cq, output longint sq);
        int m;
        int quad;
        int r;
        longint unsigned a;
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        longint ss;
        longint cs;
        longint c;
        longint s;
        m = 2 * j + 1;
        quad = (2 * m) / SIDES;
        r = 2 * m - quad * SIDES;
        a = longint'(r) * PI_Q30 / (2 * SIDES);
        x2 = (a * a) >> 30;
        ts = a;
        tc = 64'd1 << 30;
        ss = a;
        cs = 64'd1 << 30;
        for (int n = 1; n <= 7; n++)
        begin
            ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
            tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
            begin
                ss = ss - longint'(ts);
                cs = cs - longint'(tc);
            end
            else
            begin
                ss = ss + longint'(ts);
                cs = cs + longint'(tc);
            end
        end
        if (ss < 0) ss = 0;
        if (cs < 0) cs = 0;
        s = (ss + 32768) >>> 16;
        c = (cs + 32768) >>> 16;
        if (s > 16384) s = 16384;
        if (c > 16384) c = 16384;
        case (quad % 4)
            0: begin cq = c;  sq = s;  end
            1: begin cq = -s; sq = c;  end
            2: begin cq = -c; sq = -s; end
            default: begin cq = s; sq = -c; end
        endcase
    endtask

    function automatic q14_t clamp16(longint p);
        longint r;
        r = round_away(p, 44);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return q14_t'(r);
    endfunction

    task automatic predict_ring(input cell_t cl);
        tri_t u;
        tri_t t;
        tri_t b;
        longint uy_abs;
        longint rad;
        longint c;
        longint s;
        longint sh;
        int corner;
        vertex_t vx;
        u = unitize(longint'(cl.nx), longint'(cl.ny), longint'(cl.nz));
        uy_abs = (u.y < 0) ? -u.y : u.y;
        if (uy_abs > pole_reg) t = unitize(0, -u.z, u.y);
        else t = unitize(u.z, 0, -u.x);
        b = unitize(round_away(u.y * t.z - u.z * t.y, 14),
                    round_away(u.z * t.x - u.x * t.z, 14),
                    round_away(u.x * t.y - u.y * t.x, 14));
        rad = radius_reg * longint'(cl.scale);
        sh = shell_reg * (64'sd1 << 30);
        for (int v = 0; v < RING_LEN; v++)
        begin
            corner = (v >> 1) + (v & 1);
            if (corner >= SIDES) corner = corner - SIDES;
            corner_trig(corner, c, s);
            vx.px = clamp16(u.x * sh + rad * (t.x * c + b.x * s));
            vx.py = clamp16(u.y * sh + rad * (t.y * c + b.y * s));
            vx.pz = clamp16(u.z * sh + rad * (t.z * c + b.z * s));
            vx.ux = q14_t'(u.x);
            vx.uy = q14_t'(u.y);
            vx.uz = q14_t'(u.z);
            vx.energy = cl.energy;
            vx.index = 4'(v);
            vx.last = (v == RING_LEN - 1);
            ring_q = {ring_q, vx};
        end
    endtask

    // sender: bursts of items with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        cell_t nxt;
        if (!rst_n)
        begin
            cell_valid <= 1'b0;
            normal_x <= '0;
            normal_y <= '0;
            normal_z <= '0;
            cell_scale <= '0;
            cell_energy <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (cell_valid && !cell_stall)
                predict_ring('{normal_x, normal_y, normal_z, cell_scale, cell_energy});
            if (!cell_valid || !cell_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cell_valid <= 1'b0;
                end
                else if (cell_q.size() > 0)
                begin
                    nxt = cell_q.pop_front();
                    normal_x <= nxt.nx;
                    normal_y <= nxt.ny;
                    normal_z <= nxt.nz;
                    cell_scale <= nxt.scale;
                    cell_energy <= nxt.energy;
                    cell_valid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end
                else
                    cell_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, plus long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_stall <= 1'b0;
            hold_left = 0;
            holds_done = 0;
            stall_win = 0;
            stall_mode = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            vertex_stall <= 1'b1;
        end
        else if (holds_done != holds_asked)
        begin
            holds_done++;
            hold_left = 800;
            vertex_stall <= 1'b1;
        end
        else
        begin
            if (stall_win == 0)
            begin
                stall_win = $urandom_range(20, 80);
                stall_mode = $urandom_range(0, 2);
            end
            stall_win--;
            case (stall_mode)
                0: vertex_stall <= 1'b0;
                1: vertex_stall <= ($urandom_range(0, 2) == 0);
                default: vertex_stall <= (stall_win % 5 < 2);
            endcase
        end
    end

    always @(posedge clk)
    begin
        vertex_t got;
        vertex_t want;
        if (rst_n && vertex_valid && !vertex_stall)
        begin
            got = '{pos_x, pos_y, pos_z, unit_x, unit_y, unit_z,
                    vertex_energy, vertex_index, last_vertex};
            if (ring_q.size() == 0)
            begin
                failures++;
                if (mismatches < 10)
                    $display("unexpected vertex: %h", got);
                mismatches++;
            end
            else
            begin
                want = ring_q.pop_front();
                if (got !== want)
                begin
                    failures++;
                    if (mismatches < 10)
                        $display("vertex mismatch: exp pos %0d %0d %0d unit %0d %0d %0d",
                                 want.px, want.py, want.pz, want.ux, want.uy, want.uz,
                                 " e %h i %0d l %b", want.energy, want.index, want.last,
                                 " / got pos %0d %0d %0d unit %0d %0d %0d",
                                 got.px, got.py, got.pz, got.ux, got.uy, got.uz,
                                 " e %h i %0d l %b", got.energy, got.index, got.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_CELL_RADIUS: radius_reg = val;
            REG_SHELL_RADIUS: shell_reg = val & 16'h7fff;
            REG_POLE_THRESHOLD: pole_reg = val & 16'h7fff;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        while (cell_q.size() > 0 || cell_valid || ring_q.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic add_cell(input int x, input int y, input int z, input int sc, input int en);
        cell_t cl;
        cl = '{q14_t'(x), q14_t'(y), q14_t'(z), 16'(sc), 16'(en)};
        cell_q = {cell_q, cl};
    endtask

    task automatic add_random(input int n);
        int kind;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 3);
            if (kind == 0)
                add_cell($urandom, $urandom, $urandom, $urandom, $urandom);
            else if (kind == 1)
                add_cell($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                         $urandom_range(0, 64) - 32, $urandom, $urandom);
            else if (kind == 2)
                add_cell($urandom_range(0, 2000) - 1000, 16384 - $urandom_range(0, 3000),
                         $urandom_range(0, 2000) - 1000, $urandom_range(0, 20000), $urandom);
            else
                add_cell($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                         $urandom_range(0, 32768) - 16384, $urandom_range(0, 20000), $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        failures = 0;
        cycles = 0;
        holds_asked = 0;
        radius_reg = CELL_RADIUS_RST;
        shell_reg = SHELL_RADIUS_RST;
        pole_reg = POLE_THRESHOLD_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: zero normal, extremes, poles
        add_cell(0, 0, 0, 16384, 0);
        add_cell(0, 16384, 0, 16384, 16'hffff);
        add_cell(0, -16384, 0, 65535, 1);
        add_cell(16384, 0, 0, 0, 16'h8000);
        add_cell(-32768, -32768, -32768, 65535, 16'h5555);
        add_cell(32767, 32767, 32767, 65535, 16'haaaa);
        add_cell(0, 0, -32768, 16384, 16'h1234);
        add_cell(100, 15000, -100, 16384, 16'h00ff);
        wait_idle();

        write_reg(REG_CELL_RADIUS, 16'hffff);
        write_reg(REG_SHELL_RADIUS, 16'hffff);
        write_reg(REG_POLE_THRESHOLD, 16'h8000);
        write_reg(REG_UNUSED, 16'h1234);
        end_writes();
        add_cell(0, 0, 0, 65535, 16'hffff);
        add_cell(0, 1, 0, 65535, 3);
        add_cell(-32768, 32767, 0, 65535, 7);
        add_cell(5, -7, 3, 0, 9);
        add_cell(32767, -32768, 32767, 65535, 16'hffff);
        wait_idle();

        write_reg(REG_CELL_RADIUS, 16'h0000);
        write_reg(REG_SHELL_RADIUS, 16'h0000);
        write_reg(REG_POLE_THRESHOLD, 16'hc000);
        end_writes();
        add_cell(0, 16384, 0, 65535, 1);
        add_cell(0, -16384, 0, 65535, 2);
        add_cell(0, 0, 0, 65535, 3);
        add_cell(1000, -2000, 3000, 65535, 4);
        wait_idle();

        write_reg(REG_CELL_RADIUS, CELL_RADIUS_RST);
        write_reg(REG_SHELL_RADIUS, 16'(SHELL_RADIUS_RST));
        write_reg(REG_POLE_THRESHOLD, 16'(POLE_THRESHOLD_RST));
        end_writes();
        holds_asked++;
        add_random(100);
        wait_idle();

        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(REG_CELL_RADIUS, 16'($urandom));
            write_reg(REG_SHELL_RADIUS, 16'($urandom));
            write_reg(REG_POLE_THRESHOLD, 16'($urandom_range(0, 16384)));
            end_writes();
            add_random(20);
            wait_idle();
        end

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/hrve_pkg.sv
sv/hrve_norm.sv
sv/hex_ring_vertex_expander.sv
bench/tb_top.sv
